[hw/rtl/far_pkg.sv]
// package for the fraction arithmetic reduce core
// types and constants shared by the front, queue, back and top level; no dependencies
`default_nettype none
package far_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned OP_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5,
        OP_GE  = 3'd6,
        OP_LE  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        JOB_ONE = 2'd0,
        JOB_TWO = 2'd1,
        JOB_CMP = 2'd2
    } t_job_kind;

endpackage : far_pkg
`default_nettype wire

[hw/rtl/far_if.sv]
// valid/ready channel interfaces for the fraction arithmetic reduce core
// depends on far_pkg
`default_nettype none
interface far_in_if
    import far_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [FIELD_W-1:0]  a_num;
    logic signed [FIELD_W-1:0]  a_den;
    logic signed [FIELD_W-1:0]  b_num;
    logic signed [FIELD_W-1:0]  b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface : far_in_if

interface far_out_if
    import far_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  res_num;
    logic signed [FIELD_W-1:0]  res_den;
    logic                       compare_true;
    logic                       status;

    modport source (output valid, res_num, res_den, compare_true, status, input ready);
    modport sink   (input valid, res_num, res_den, compare_true, status, output ready);
endinterface : far_out_if
`default_nettype wire

[hw/rtl/far_front.sv]
// front end: accepts an item, forms the cross products, classifies the job
// depends on far_pkg
`default_nettype none
module far_front
    import far_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [FIELD_W-1:0] i_a_num,
    input  wire logic [FIELD_W-1:0] i_a_den,
    input  wire logic [FIELD_W-1:0] i_b_num,
    input  wire logic [FIELD_W-1:0] i_b_den,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_job_kind               o_kind,
    output logic [OP_W-1:0]         o_op,
    output logic [WIDTH-1:0]        o_x0,
    output logic [WIDTH-1:0]        o_y0,
    output logic [WIDTH-1:0]        o_x1,
    output logic [WIDTH-1:0]        o_y1,
    output logic                    o_cmp
);

    typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_OUT} t_state;

    t_state             r_state;
    logic [OP_W-1:0]    r_op;
    logic [FIELD_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDTH-1:0]   r_p0, r_p1, r_p2;
    logic [WIDTH-1:0]   r_x0, r_y0, r_x1, r_y1;
    t_job_kind          r_kind;
    logic               r_cmp;

    logic [FIELD_W-1:0]          w_ma, w_mb;
    logic signed [2*FIELD_W-1:0] w_full;
    logic [WIDTH-1:0]            w_prod;
    logic [WIDTH-1:0]            w_sb_x, w_sb_y;

    function automatic logic [WIDTH-1:0] ext(input logic [FIELD_W-1:0] v);
        logic [WIDTH+FIELD_W-1:0] t;
        t = {{WIDTH{v[FIELD_W-1]}}, v};
        return t[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] fit(input logic [2*FIELD_W-1:0] v);
        logic [WIDTH+2*FIELD_W-1:0] t;
        t = {{WIDTH{v[2*FIELD_W-1]}}, v};
        return t[WIDTH-1:0];
    endfunction

    // one shared multiplier, operands chosen per step
    always_comb begin
        unique case (r_state)
            S_MUL0:  begin w_ma = r_an; w_mb = (r_op == OP_MUL) ? r_bn : r_bd; end
            S_MUL1:  begin w_ma = r_ad; w_mb = (r_op == OP_MUL) ? r_bd : r_bn; end
            default: begin w_ma = r_ad; w_mb = r_bd; end
        endcase
    end
    // full signed product of the 32-bit fields, wrapped to the working width
    assign w_full = $signed(w_ma) * $signed(w_mb);
    assign w_prod = fit(w_full);

    assign w_sb_x = {~r_p0[WIDTH-1], r_p0[WIDTH-2:0]};
    assign w_sb_y = {~r_p1[WIDTH-1], r_p1[WIDTH-2:0]};

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_kind  = r_kind;
    assign o_op    = r_op;
    assign o_x0    = r_x0;
    assign o_y0    = r_y0;
    assign o_x1    = r_x1;
    assign o_y1    = r_y1;
    assign o_cmp   = r_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_operation;
                        r_an    <= i_a_num;
                        r_ad    <= i_a_den;
                        r_bn    <= i_b_num;
                        r_bd    <= i_b_den;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0    <= w_prod;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= w_prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= w_prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_cmp <= 1'b0;
                    r_x0  <= ext(r_an);
                    r_y0  <= ext(r_ad);
                    r_x1  <= ext(r_bn);
                    r_y1  <= ext(r_bd);
                    unique case (r_op)
                        OP_ADD: begin r_kind <= JOB_ONE; r_x0 <= r_p0 + r_p1; r_y0 <= r_p2; end
                        OP_SUB: begin r_kind <= JOB_ONE; r_x0 <= r_p0 - r_p1; r_y0 <= r_p2; end
                        OP_MUL, OP_DIV: begin
                            r_kind <= JOB_ONE;
                            r_x0   <= r_p0;
                            r_y0   <= r_p1;
                        end
                        OP_EQ, OP_NE: r_kind <= JOB_TWO;
                        OP_GE: begin r_kind <= JOB_CMP; r_cmp <= (w_sb_x >= w_sb_y); end
                        OP_LE: begin r_kind <= JOB_CMP; r_cmp <= (w_sb_x <= w_sb_y); end
                        default: r_kind <= JOB_CMP;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule : far_front
`default_nettype wire

[hw/rtl/far_queue.sv]
// two-entry job queue between front and back
// depends on far_pkg
`default_nettype none
module far_queue
    import far_pkg::*;
#(
    parameter int unsigned DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [DW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [DW-1:0]      o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule : far_queue
`default_nettype wire

[hw/rtl/far_divu.sv]
// iterative unsigned divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module far_divu #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_quo,
    output logic [WIDTH-1:0]      o_rem
);

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q, r_r, r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH:0]   w_sh, w_diff;

    assign w_sh   = {r_r, r_q[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CW'(WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[WIDTH]) begin
                    r_r <= w_diff[WIDTH-1:0];
                    r_q <= {r_q[WIDTH-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[WIDTH-1:0];
                    r_q <= {r_q[WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule : far_divu
`default_nettype wire

[hw/rtl/far_back.sv]
// back end: gcd reduction through a shared iterative divider, compare and result register
// depends on far_pkg and far_divu
`default_nettype none
module far_back
    import far_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_job_kind          i_kind,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [WIDTH-1:0]   i_x0,
    input  wire logic [WIDTH-1:0]   i_y0,
    input  wire logic [WIDTH-1:0]   i_x1,
    input  wire logic [WIDTH-1:0]   i_y1,
    input  wire logic               i_cmp,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [FIELD_W-1:0]      o_res_num,
    output logic [FIELD_W-1:0]      o_res_den,
    output logic                    o_compare_true,
    output logic                    o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GTEST, S_GWAIT, S_GDONE, S_QX, S_QXW, S_QY, S_QYW, S_NEXT, S_FIN, S_OUT
    } t_state;

    t_state           r_state;
    t_job_kind        r_kind;
    logic [OP_W-1:0]  r_op;
    logic [WIDTH-1:0] r_x1, r_y1;
    logic             r_cmp;
    logic             r_pass;
    logic [WIDTH-1:0] r_x, r_y, r_p, r_q, r_g, r_rx, r_ry;
    logic [WIDTH-1:0] r_rx0, r_ry0;
    logic             r_bad;
    logic [FIELD_W-1:0] r_onum, r_oden;
    logic             r_ocmp, r_ost;

    logic             r_start;
    logic [WIDTH-1:0] r_dvd, r_dvs;
    logic             r_negres;
    logic             w_done;
    logic [WIDTH-1:0] w_quo, w_rem, w_sres, w_gabs;

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] v);
        logic [WIDTH+FIELD_W-1:0] t;
        t = {{FIELD_W{v[WIDTH-1]}}, v};
        return t[FIELD_W-1:0];
    endfunction

    far_divu #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // sign applied after magnitude division
    assign w_sres = r_negres ? (~(r_state == S_GWAIT ? w_rem : w_quo) + 1'b1)
                             : (r_state == S_GWAIT ? w_rem : w_quo);
    assign w_gabs = r_p[WIDTH-1] ? (~r_p + 1'b1) : r_p;

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_res_num      = r_onum;
    assign o_res_den      = r_oden;
    assign o_compare_true = r_ocmp;
    assign o_status       = r_ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_op    <= i_op;
                        r_x     <= i_x0;
                        r_y     <= i_y0;
                        r_x1    <= i_x1;
                        r_y1    <= i_y1;
                        r_cmp   <= i_cmp;
                        r_pass  <= 1'b0;
                        r_bad   <= 1'b0;
                        r_state <= (i_kind == JOB_CMP) ? S_FIN : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_p     <= r_x;
                    r_q     <= r_y;
                    r_state <= S_GTEST;
                end
                S_GTEST: begin
                    if (r_q == '0) begin
                        r_state <= S_GDONE;
                    end else begin
                        r_dvd    <= mag(r_p);
                        r_dvs    <= mag(r_q);
                        r_negres <= r_p[WIDTH-1];
                        r_start  <= 1'b1;
                        r_state  <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_done) begin
                        r_p     <= r_q;
                        r_q     <= w_sres;
                        r_state <= S_GTEST;
                    end
                end
                S_GDONE: begin
                    r_g <= w_gabs;
                    if (w_gabs == '0) begin
                        r_bad   <= 1'b1;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_QX;
                    end
                end
                S_QX: begin
                    r_dvd    <= mag(r_x);
                    r_dvs    <= mag(r_g);
                    r_negres <= r_x[WIDTH-1] ^ r_g[WIDTH-1];
                    r_start  <= 1'b1;
                    r_state  <= S_QXW;
                end
                S_QXW: begin
                    if (w_done) begin
                        r_rx    <= w_sres;
                        r_state <= S_QY;
                    end
                end
                S_QY: begin
                    r_dvd    <= mag(r_y);
                    r_dvs    <= mag(r_g);
                    r_negres <= r_y[WIDTH-1] ^ r_g[WIDTH-1];
                    r_start  <= 1'b1;
                    r_state  <= S_QYW;
                end
                S_QYW: begin
                    if (w_done) begin
                        r_ry    <= w_sres;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_kind == JOB_TWO && !r_pass) begin
                        r_pass  <= 1'b1;
                        r_rx0   <= r_rx;
                        r_ry0   <= r_ry;
                        r_x     <= r_x1;
                        r_y     <= r_y1;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_onum <= '0;
                    r_oden <= '0;
                    r_ocmp <= 1'b0;
                    r_ost  <= r_bad;
                    unique case (r_kind)
                        JOB_ONE: begin
                            r_onum <= to_field(r_rx);
                            r_oden <= to_field(r_ry);
                        end
                        JOB_TWO: begin
                            if (!r_bad) begin
                                r_ocmp <= ((r_rx0 == r_rx) && (r_ry0 == r_ry))
                                          ^ (r_op == OP_NE);
                            end
                        end
                        default: r_ocmp <= r_cmp;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule : far_back
`default_nettype wire

[hw/rtl/fraction_arith_reduce_core.sv]
// top level of the fraction arithmetic reduce core
// depends on far_pkg, far_if, far_front, far_queue, far_back, far_divu
`default_nettype none
// One item in, one result out. The front end steps through S_MUL0, S_MUL1, S_MUL2 and S_COMB
// before presenting its job, forming the cross products on one shared 32 by 32 multiplier; the
// back end reduces by Euclid's GCD on one shared bit-serial divider. Eq and ne run two reductions
// and ge and le skip the divider. A two-entry queue lets the front accept while the back is busy.
module fraction_arith_reduce_core
    import far_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    far_in_if.sink    i_in,
    far_out_if.source o_out
);

    localparam int unsigned QW = 2 + OP_W + 4 * WIDTH + 1;

    logic             f_valid, f_ready, f_cmp;
    t_job_kind        f_kind;
    logic [OP_W-1:0]  f_op;
    logic [WIDTH-1:0] f_x0, f_y0, f_x1, f_y1;
    logic [QW-1:0]    q_in, q_out;
    logic             q_valid, q_ready;

    far_front #(.WIDTH(WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_operation (i_in.operation),
        .i_a_num     (i_in.a_num),
        .i_a_den     (i_in.a_den),
        .i_b_num     (i_in.b_num),
        .i_b_den     (i_in.b_den),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_kind      (f_kind),
        .o_op        (f_op),
        .o_x0        (f_x0),
        .o_y0        (f_y0),
        .o_x1        (f_x1),
        .o_y1        (f_y1),
        .o_cmp       (f_cmp)
    );

    assign q_in = {f_kind, f_op, f_x0, f_y0, f_x1, f_y1, f_cmp};

    far_queue #(.DW(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_out)
    );

    far_back #(.WIDTH(WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_kind         (t_job_kind'(q_out[QW-1 -: 2])),
        .i_op           (q_out[QW-3 -: OP_W]),
        .i_x0           (q_out[4*WIDTH -: WIDTH]),
        .i_y0           (q_out[3*WIDTH -: WIDTH]),
        .i_x1           (q_out[2*WIDTH -: WIDTH]),
        .i_y1           (q_out[WIDTH -: WIDTH]),
        .i_cmp          (q_out[0]),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_res_num      (o_out.res_num),
        .o_res_den      (o_out.res_den),
        .o_compare_true (o_out.compare_true),
        .o_status       (o_out.status)
    );

endmodule : fraction_arith_reduce_core
`default_nettype wire
